>>> design/sri_pkg.sv
// ============================================================================
// sri_pkg: shared types and constants of the stack robot interpreter
// Opcodes, status and action codes, controller command and status records.
// ============================================================================
`default_nettype none

package sri_pkg;

    // Opcodes of a program word.
    localparam logic [4:0] OP_MOVE    = 5'd0;
    localparam logic [4:0] OP_LEFT    = 5'd1;
    localparam logic [4:0] OP_RIGHT   = 5'd2;
    localparam logic [4:0] OP_MEASURE = 5'd3;
    localparam logic [4:0] OP_MARK    = 5'd4;
    localparam logic [4:0] OP_BSTART  = 5'd5;
    localparam logic [4:0] OP_BEND    = 5'd6;
    localparam logic [4:0] OP_PUSH    = 5'd7;
    localparam logic [4:0] OP_EXEC    = 5'd8;
    localparam logic [4:0] OP_IFELSE  = 5'd9;
    localparam logic [4:0] OP_SWAP    = 5'd10;
    localparam logic [4:0] OP_MUL     = 5'd11;
    localparam logic [4:0] OP_ADD     = 5'd12;
    localparam logic [4:0] OP_DIV     = 5'd13;
    localparam logic [4:0] OP_SUB     = 5'd14;
    localparam logic [4:0] OP_ROT     = 5'd15;
    localparam logic [4:0] OP_DUP     = 5'd16;
    localparam logic [4:0] OP_LOOP    = 5'd17;
    localparam logic [4:0] OP_DROP    = 5'd18;

    // Status codes of a result word.
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_STOPPED = 4'd1;
    localparam logic [3:0] ST_WATER   = 4'd2;
    localparam logic [3:0] ST_CRASH   = 4'd3;
    localparam logic [3:0] ST_OFFMAP  = 4'd4;
    localparam logic [3:0] ST_BADADDR = 4'd5;
    localparam logic [3:0] ST_SHORT   = 4'd6;
    localparam logic [3:0] ST_DIVZERO = 4'd7;
    localparam logic [3:0] ST_FULL    = 4'd8;

    // Robot actions.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_MOVE    = 3'd1;
    localparam logic [2:0] ACT_LEFT    = 3'd2;
    localparam logic [2:0] ACT_RIGHT   = 3'd3;
    localparam logic [2:0] ACT_MEASURE = 3'd4;

    // Input word kinds.
    localparam logic FUNC_LOAD = 1'b0;

    // Register index bit of the configuration port.
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_FETCH,
        CMD_RD1,
        CMD_RD2,
        CMD_RD3,
        CMD_EXEC,
        CMD_WR2,
        CMD_DIV,
        CMD_ROTA,
        CMD_ROTAE,
        CMD_ROTB,
        CMD_ROTBE,
        CMD_TOP,
        CMD_TOPW,
        CMD_HOLD
    } t_cmd;

    // Where execution goes after the execute cycle.
    typedef enum logic [1:0] {
        RT_DONE,
        RT_WR2,
        RT_DIV
    } t_route;

    typedef struct packed {
        t_cmd op;
        logic accept;
    } t_ctl;

    typedef struct packed {
        logic   early;
        t_route route;
        logic   div_done;
        logic   is_rot;
        logic   last;
    } t_stat;

endpackage

`default_nettype wire

>>> design/sri_ram.sv
// ============================================================================
// sri_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module sri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/sri_div.sv
// ============================================================================
// sri_div: iterative signed divider
// Restoring division, one quotient bit a cycle; truncates toward zero.
// ============================================================================
`default_nettype none

module sri_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_dividend,
    input  wire logic signed [31:0] i_divisor,
    output logic                    o_done,
    output logic signed [31:0]      o_quot,
    output logic signed [31:0]      o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_d;
    logic        r_sq;
    logic        r_sr;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign w_sh   = {r_rem, r_q[31]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'd31)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operand magnitudes and the iteration itself.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= 5'd0;
            r_rem <= 32'd0;
            r_q   <= i_dividend[31] ? 32'(-i_dividend) : i_dividend;
            r_d   <= i_divisor[31] ? 32'(-i_divisor) : i_divisor;
            r_sq  <= i_dividend[31] ^ i_divisor[31];
            r_sr  <= i_dividend[31];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sq ? 32'(-r_q) : r_q;
    assign o_rem  = r_sr ? 32'(-r_rem) : r_rem;

endmodule

`default_nettype wire

>>> design/sri_ctrl.sv
// ============================================================================
// sri_ctrl: sequencing state machine of the interpreter
// Walks each executed word through fetch, operand reads, execute, divide or rotate and result stages.
// ============================================================================
`default_nettype none

module sri_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire sri_pkg::t_stat i_stat,
    output sri_pkg::t_ctl       o_ctl
);

    import sri_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_FETCH = 15'h0002,
        S_RD1   = 15'h0004,
        S_RD2   = 15'h0008,
        S_RD3   = 15'h0010,
        S_EXEC  = 15'h0020,
        S_WR2   = 15'h0040,
        S_DIV   = 15'h0080,
        S_ROTA  = 15'h0100,
        S_ROTAE = 15'h0200,
        S_ROTB  = 15'h0400,
        S_ROTBE = 15'h0800,
        S_TOP   = 15'h1000,
        S_TOPW  = 15'h2000,
        S_OUT   = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.early ? S_TOP : S_FETCH;
                end
            end
            S_FETCH: n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_EXEC;
            S_EXEC: begin
                unique case (i_stat.route)
                    RT_WR2:  n_state = S_WR2;
                    RT_DIV:  n_state = S_DIV;
                    default: n_state = S_TOP;
                endcase
            end
            S_WR2: n_state = S_TOP;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.is_rot ? S_ROTA : S_TOP;
                end
            end
            S_ROTA: begin
                if (i_stat.last) begin
                    n_state = S_ROTAE;
                end
            end
            S_ROTAE: n_state = S_ROTB;
            S_ROTB: begin
                if (i_stat.last) begin
                    n_state = S_ROTBE;
                end
            end
            S_ROTBE: n_state = S_TOP;
            S_TOP:   n_state = S_TOPW;
            S_TOPW:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command to the datapath.
    always_comb begin
        o_ctl.accept = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE:  o_ctl.op = CMD_IDLE;
            S_FETCH: o_ctl.op = CMD_FETCH;
            S_RD1:   o_ctl.op = CMD_RD1;
            S_RD2:   o_ctl.op = CMD_RD2;
            S_RD3:   o_ctl.op = CMD_RD3;
            S_EXEC:  o_ctl.op = CMD_EXEC;
            S_WR2:   o_ctl.op = CMD_WR2;
            S_DIV:   o_ctl.op = CMD_DIV;
            S_ROTA:  o_ctl.op = CMD_ROTA;
            S_ROTAE: o_ctl.op = CMD_ROTAE;
            S_ROTB:  o_ctl.op = CMD_ROTB;
            S_ROTBE: o_ctl.op = CMD_ROTBE;
            S_TOP:   o_ctl.op = CMD_TOP;
            S_TOPW:  o_ctl.op = CMD_TOPW;
            default: o_ctl.op = CMD_HOLD;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

`default_nettype wire

>>> design/sri_dpath.sv
// ============================================================================
// sri_dpath: datapath of the interpreter
// Program memory, both stacks, operand registers, execute logic and divider.
// ============================================================================
`default_nettype none

module sri_dpath #(
    parameter int PROGRAM_DEPTH      = 256,
    parameter int DATA_STACK_DEPTH   = 64,
    parameter int RETURN_STACK_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sri_pkg::t_ctl      i_ctl,
    output sri_pkg::t_stat          o_stat,
    input  wire logic               i_func,
    input  wire logic [7:0]         i_load_address,
    input  wire logic [4:0]         i_load_opcode,
    input  wire logic signed [31:0] i_load_operand,
    input  wire logic [1:0]         i_move_outcome,
    input  wire logic signed [31:0] i_measure_value,
    input  wire logic               i_cfg_we,
    input  wire logic [8:0]         i_cfg_wdata,
    output logic [8:0]              o_program_length,
    output logic [3:0]              o_status,
    output logic signed [31:0]      o_program_counter,
    output logic [2:0]              o_robot_action,
    output logic signed [31:0]      o_measure_param,
    output logic signed [31:0]      o_top_value,
    output logic [$clog2(DATA_STACK_DEPTH+1)-1:0] o_stack_depth
);

    import sri_pkg::*;

    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int DAW = $clog2(DATA_STACK_DEPTH);
    localparam int RAW = $clog2(RETURN_STACK_DEPTH);
    localparam int DCW = $clog2(DATA_STACK_DEPTH + 1);
    localparam int RCW = $clog2(RETURN_STACK_DEPTH + 1);

    // Architectural state.
    logic [31:0]    r_pc;
    logic [DCW-1:0] r_dc;
    logic [RCW-1:0] r_rc;
    logic [8:0]     r_plen;

    // Per-word registers.
    logic [4:0]     r_op;
    logic [31:0]    r_arg;
    logic [1:0]     r_outcome;
    logic [31:0]    r_mval;
    logic [31:0]    r_a;
    logic [31:0]    r_b;
    logic [31:0]    r_c;
    logic [31:0]    r_ret;
    logic [3:0]     r_status;
    logic [2:0]     r_action;
    logic [31:0]    r_mparam;
    logic [31:0]    r_top;
    logic           r_isload;

    // Rotate walk.
    logic [DCW-1:0] r_n;
    logic [DCW-1:0] r_base;
    logic [DAW-1:0] r_idx;
    logic [DAW-1:0] r_pidx;
    logic [DAW-1:0] r_k;
    logic           r_pend;

    // Memory ports.
    logic [36:0]    prog_rdata;
    logic           prog_we;
    logic [31:0]    ds_rdata;
    logic [DAW-1:0] ds_raddr;
    logic           ds_we;
    logic [DAW-1:0] ds_waddr;
    logic [31:0]    ds_wdata;
    logic [31:0]    rs_rdata;
    logic           rs_we;
    logic [31:0]    tmp_rdata;
    logic           tmp_we;

    // Divider.
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic signed [31:0] div_rem;
    logic signed [31:0] div_dvd;
    logic signed [31:0] div_dvs;

    // Execute results.
    logic [3:0]     ex_status;
    t_route         ex_route;
    logic [31:0]    ex_pc;
    logic [DCW-1:0] ex_dc;
    logic [RCW-1:0] ex_rc;
    logic [2:0]     ex_action;
    logic [31:0]    ex_mparam;
    logic           ex_ds_we;
    logic [DCW-1:0] ex_ds_wa;
    logic [31:0]    ex_ds_wd;
    logic           ex_rs_we;
    logic [31:0]    ex_rs_wd;

    logic [31:0]    pc1;
    logic [DCW-1:0] dc2;
    logic           dfull;
    logic           rfull;
    logic           is_rot;
    logic [31:0]    plen32;
    logic           pc_stop;
    logic           pc_bad;
    logic           load_ok;
    logic [31:0]    sh;

    assign pc1     = r_pc + 32'd1;
    assign dc2     = r_dc - DCW'(2);
    assign dfull   = (r_dc >= DCW'(DATA_STACK_DEPTH));
    assign rfull   = (r_rc >= RCW'(RETURN_STACK_DEPTH));
    assign is_rot  = (r_op == OP_ROT);
    assign plen32  = 32'(r_plen);
    assign pc_stop = (r_pc == plen32);
    assign pc_bad  = r_pc[31] || (r_pc > plen32) || (r_pc >= 32'(PROGRAM_DEPTH));
    assign load_ok = (32'(i_load_address) < 32'(PROGRAM_DEPTH));
    assign sh      = div_rem[31] ? 32'(div_rem + 32'(r_n)) : div_rem;

    // Execute one opcode from the operand registers.
    always_comb begin
        ex_status = ST_OK;
        ex_route  = RT_DONE;
        ex_pc     = r_pc;
        ex_dc     = r_dc;
        ex_rc     = r_rc;
        ex_action = ACT_NONE;
        ex_mparam = 32'd0;
        ex_ds_we  = 1'b0;
        ex_ds_wa  = r_dc;
        ex_ds_wd  = 32'd0;
        ex_rs_we  = 1'b0;
        ex_rs_wd  = pc1;
        unique case (r_op)
            OP_MOVE: begin
                ex_action = ACT_MOVE;
                if (r_outcome == 2'd0) begin
                    ex_pc = pc1;
                end else begin
                    ex_status = 4'(r_outcome) + 4'd1;
                end
            end
            OP_LEFT: begin
                ex_action = ACT_LEFT;
                ex_pc     = pc1;
            end
            OP_RIGHT: begin
                ex_action = ACT_RIGHT;
                ex_pc     = pc1;
            end
            OP_MEASURE: begin
                if (r_dc == '0) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_action = ACT_MEASURE;
                    ex_mparam = r_a;
                    ex_ds_we  = 1'b1;
                    ex_ds_wa  = r_dc - DCW'(1);
                    ex_ds_wd  = r_mval;
                    ex_pc     = pc1;
                end
            end
            OP_BSTART: begin
                if (dfull) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_ds_we = 1'b1;
                    ex_ds_wd = pc1;
                    ex_dc    = r_dc + DCW'(1);
                    ex_pc    = r_arg + 32'd1;
                end
            end
            OP_BEND: begin
                if (r_rc == '0) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_pc = r_ret;
                    ex_rc = r_rc - RCW'(1);
                end
            end
            OP_PUSH: begin
                if (dfull) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_ds_we = 1'b1;
                    ex_ds_wd = r_arg;
                    ex_dc    = r_dc + DCW'(1);
                    ex_pc    = pc1;
                end
            end
            OP_EXEC: begin
                if (r_dc == '0) begin
                    ex_status = ST_SHORT;
                end else if (rfull) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_rs_we = 1'b1;
                    ex_rc    = r_rc + RCW'(1);
                    ex_pc    = r_a;
                    ex_dc    = r_dc - DCW'(1);
                end
            end
            OP_IFELSE: begin
                if (r_dc < DCW'(3)) begin
                    ex_status = ST_SHORT;
                end else if (rfull) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_rs_we = 1'b1;
                    ex_rc    = r_rc + RCW'(1);
                    ex_dc    = r_dc - DCW'(3);
                    ex_pc    = (r_c != 32'd0) ? r_b : r_a;
                end
            end
            OP_SWAP: begin
                if (r_dc < DCW'(2)) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_ds_we = 1'b1;
                    ex_ds_wa = r_dc - DCW'(1);
                    ex_ds_wd = r_b;
                    ex_route = RT_WR2;
                    ex_pc    = pc1;
                end
            end
            OP_MUL, OP_ADD, OP_SUB: begin
                if (r_dc < DCW'(2)) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_ds_we = 1'b1;
                    ex_ds_wa = dc2;
                    if (r_op == OP_MUL) begin
                        ex_ds_wd = 32'(r_b * r_a);
                    end else if (r_op == OP_ADD) begin
                        ex_ds_wd = r_b + r_a;
                    end else begin
                        ex_ds_wd = r_b - r_a;
                    end
                    ex_dc = r_dc - DCW'(1);
                    ex_pc = pc1;
                end
            end
            OP_DIV: begin
                if (r_dc < DCW'(2)) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_dc = dc2;
                    if (r_a == 32'd0) begin
                        ex_status = ST_DIVZERO;
                    end else begin
                        ex_route = RT_DIV;
                        ex_pc    = pc1;
                    end
                end
            end
            OP_ROT: begin
                if (r_dc < DCW'(2)) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_dc = dc2;
                    // A negative count acts as zero.
                    if (!r_b[31] && (r_b > 32'(dc2))) begin
                        ex_status = ST_SHORT;
                    end else if (r_b[31] || (r_b == 32'd0)) begin
                        ex_pc = pc1;
                    end else begin
                        ex_route = RT_DIV;
                        ex_pc    = pc1;
                    end
                end
            end
            OP_DUP: begin
                if (r_dc == '0) begin
                    ex_status = ST_SHORT;
                end else if (dfull) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_ds_we = 1'b1;
                    ex_ds_wd = r_a;
                    ex_dc    = r_dc + DCW'(1);
                    ex_pc    = pc1;
                end
            end
            OP_LOOP: begin
                if (r_dc < DCW'(2)) begin
                    ex_status = ST_SHORT;
                end else if (!r_a[31] && (r_a != 32'd0)) begin
                    if (rfull) begin
                        ex_status = ST_FULL;
                    end else begin
                        ex_ds_we = 1'b1;
                        ex_ds_wa = r_dc - DCW'(1);
                        ex_ds_wd = r_a - 32'd1;
                        ex_rs_we = 1'b1;
                        ex_rs_wd = r_pc;
                        ex_rc    = r_rc + RCW'(1);
                        ex_pc    = r_b;
                    end
                end else begin
                    ex_dc = dc2;
                    ex_pc = pc1;
                end
            end
            OP_DROP: begin
                if (r_dc == '0) begin
                    ex_status = ST_SHORT;
                end else begin
                    ex_dc = r_dc - DCW'(1);
                    ex_pc = pc1;
                end
            end
            default: begin
                // Mark and unused opcodes just advance.
                ex_pc = pc1;
            end
        endcase
    end

    // Data stack read address.
    always_comb begin
        unique case (i_ctl.op)
            CMD_RD1:  ds_raddr = DAW'(r_dc - DCW'(2));
            CMD_RD2:  ds_raddr = DAW'(r_dc - DCW'(3));
            CMD_ROTA: ds_raddr = DAW'(r_base + DCW'(r_idx));
            default:  ds_raddr = DAW'(r_dc - DCW'(1));
        endcase
    end

    // Data stack write port.
    always_comb begin
        ds_we    = 1'b0;
        ds_waddr = DAW'(r_dc);
        ds_wdata = ex_ds_wd;
        unique case (i_ctl.op)
            CMD_EXEC: begin
                ds_we    = ex_ds_we;
                ds_waddr = DAW'(ex_ds_wa);
            end
            CMD_WR2: begin
                ds_we    = 1'b1;
                ds_waddr = DAW'(r_dc - DCW'(2));
                ds_wdata = r_a;
            end
            CMD_DIV: begin
                ds_we    = div_done && !is_rot;
                ds_wdata = div_quot;
            end
            CMD_ROTB, CMD_ROTBE: begin
                ds_we    = r_pend || (i_ctl.op == CMD_ROTBE);
                ds_waddr = DAW'(r_base + DCW'(r_pidx));
                ds_wdata = tmp_rdata;
            end
            default: begin
                ds_we = 1'b0;
            end
        endcase
    end

    assign rs_we     = (i_ctl.op == CMD_EXEC) && ex_rs_we;
    assign tmp_we    = ((i_ctl.op == CMD_ROTA) && r_pend) || (i_ctl.op == CMD_ROTAE);
    assign prog_we   = i_ctl.accept && (i_func == FUNC_LOAD) && load_ok;
    assign div_start = (i_ctl.op == CMD_EXEC) && (ex_route == RT_DIV);
    assign div_dvd   = is_rot ? r_a : r_b;
    assign div_dvs   = is_rot ? r_b : r_a;

    sri_ram #(.WIDTH(37), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (PAW'(i_load_address)),
        .i_wdata ({i_load_opcode, i_load_operand}),
        .i_raddr (PAW'(r_pc)),
        .o_rdata (prog_rdata)
    );

    sri_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_dstack (
        .i_clk   (i_clk),
        .i_we    (ds_we),
        .i_waddr (ds_waddr),
        .i_wdata (ds_wdata),
        .i_raddr (ds_raddr),
        .o_rdata (ds_rdata)
    );

    sri_ram #(.WIDTH(32), .DEPTH(RETURN_STACK_DEPTH)) u_rstack (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (RAW'(r_rc)),
        .i_wdata (ex_rs_wd),
        .i_raddr (RAW'(r_rc - RCW'(1))),
        .o_rdata (rs_rdata)
    );

    // Scratch copy of the rotated span.
    sri_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_rotbuf (
        .i_clk   (i_clk),
        .i_we    (tmp_we),
        .i_waddr (r_pidx),
        .i_wdata (ds_rdata),
        .i_raddr (r_k),
        .o_rdata (tmp_rdata)
    );

    sri_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Control state: pc, stack counts and the program length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= 32'd0;
            r_dc   <= '0;
            r_rc   <= '0;
            r_plen <= 9'd0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            if (i_ctl.op == CMD_EXEC) begin
                r_pc <= ex_pc;
                r_dc <= ex_dc;
                r_rc <= ex_rc;
            end else if ((i_ctl.op == CMD_DIV) && div_done && !is_rot) begin
                r_dc <= r_dc + DCW'(1);
            end
        end
    end

    // Per-word payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CMD_IDLE: begin
                if (i_ctl.accept) begin
                    r_isload  <= (i_func == FUNC_LOAD);
                    r_outcome <= i_move_outcome;
                    r_mval    <= i_measure_value;
                    r_action  <= ACT_NONE;
                    r_mparam  <= 32'd0;
                    if (i_func == FUNC_LOAD) begin
                        r_status <= ST_OK;
                    end else if (pc_stop) begin
                        r_status <= ST_STOPPED;
                    end else if (pc_bad) begin
                        r_status <= ST_BADADDR;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
            end
            CMD_FETCH: begin
                r_op  <= prog_rdata[36:32];
                r_arg <= prog_rdata[31:0];
            end
            CMD_RD1: begin
                r_a   <= ds_rdata;
                r_ret <= rs_rdata;
            end
            CMD_RD2: r_b <= ds_rdata;
            CMD_RD3: r_c <= ds_rdata;
            CMD_EXEC: begin
                r_status <= ex_status;
                r_action <= ex_action;
                r_mparam <= ex_mparam;
                r_n      <= DCW'(r_b);
                r_base   <= dc2 - DCW'(r_b);
            end
            CMD_DIV: begin
                if (div_done) begin
                    r_k    <= DAW'(sh);
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                end
            end
            CMD_ROTA: begin
                r_pend <= 1'b1;
                r_pidx <= r_idx;
                r_idx  <= r_idx + DAW'(1);
            end
            CMD_ROTAE: begin
                r_pend <= 1'b0;
                r_idx  <= '0;
            end
            CMD_ROTB: begin
                r_pend <= 1'b1;
                r_pidx <= r_idx;
                r_idx  <= r_idx + DAW'(1);
                r_k    <= (r_k == DAW'(r_n - DCW'(1))) ? '0 : r_k + DAW'(1);
            end
            CMD_TOPW: begin
                r_top <= (r_dc != '0) ? ds_rdata : 32'd0;
                // A successful step that lands on the program end reports a stop.
                if (!r_isload && (r_status == ST_OK) && pc_stop) begin
                    r_status <= ST_STOPPED;
                end
            end
            default: begin
                r_pend <= r_pend;
            end
        endcase
    end

    // Status to the controller.
    always_comb begin
        o_stat.early    = (i_func == FUNC_LOAD) || pc_stop || pc_bad;
        o_stat.route    = ex_route;
        o_stat.div_done = div_done;
        o_stat.is_rot   = is_rot;
        o_stat.last     = (r_idx == DAW'(r_n - DCW'(1)));
    end

    assign o_program_length  = r_plen;
    assign o_status          = r_status;
    assign o_program_counter = r_pc;
    assign o_robot_action    = r_action;
    assign o_measure_param   = r_mparam;
    assign o_top_value       = r_top;
    assign o_stack_depth     = r_dc;

endmodule

`default_nettype wire

>>> design/stack_robot_interpreter_step_unit.sv
// ============================================================================
// stack_robot_interpreter_step_unit: stack machine core for robot commands
// Loads program words and executes one word per step, reporting the outcome.
// ============================================================================
//  channel  | handshake               | contents
//  ---------+-------------------------+-----------------------------------------
//  input    | i_in_valid / o_in_ready | func, load word, move outcome, measure
//  output   | o_out_valid/i_out_ready | status, pc, action, param, top, depth
//  config   | APB psel/penable/pready | program_length at byte address 0
//
//  A load word, a stop or a bad address goes from acceptance straight to the
//  top-of-stack read and its result; an executed word has the sequencer visiting fetch,
//  three stack reads over the single read port, execute and a top-of-stack read.
//  A swap adds a write state for its second entry. A divide, and a rotate by a
//  positive count, also pass through the bit-serial divider; such a rotate then
//  copies its n entries through the scratch RAM.
//  One word is in flight at a time; a new word is taken once the result word
//  has been collected. Reset is synchronous, clears pc, both stack counts and
//  the program length.
// ============================================================================
`default_nettype none

module stack_robot_interpreter_step_unit #(
    parameter int PROGRAM_DEPTH      = 256,
    parameter int DATA_STACK_DEPTH   = 64,
    parameter int RETURN_STACK_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_func,
    input  wire logic [7:0]         i_load_address,
    input  wire logic [4:0]         i_load_opcode,
    input  wire logic signed [31:0] i_load_operand,
    input  wire logic [1:0]         i_move_outcome,
    input  wire logic signed [31:0] i_measure_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [3:0]              o_status,
    output logic signed [31:0]      o_program_counter,
    output logic [2:0]              o_robot_action,
    output logic signed [31:0]      o_measure_param,
    output logic signed [31:0]      o_top_value,
    output logic [$clog2(DATA_STACK_DEPTH+1)-1:0] o_stack_depth,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    import sri_pkg::*;

    t_ctl       ctl;
    t_stat      stat;
    logic       cfg_we;
    logic [8:0] plen;

    // Register port: always ready, one register.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PROGRAM_LENGTH);
    assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? 32'(plen) : 32'd0;

    sri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    sri_dpath #(
        .PROGRAM_DEPTH      (PROGRAM_DEPTH),
        .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
        .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_func            (i_func),
        .i_load_address    (i_load_address),
        .i_load_opcode     (i_load_opcode),
        .i_load_operand    (i_load_operand),
        .i_move_outcome    (i_move_outcome),
        .i_measure_value   (i_measure_value),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (pwdata[8:0]),
        .o_program_length  (plen),
        .o_status          (o_status),
        .o_program_counter (o_program_counter),
        .o_robot_action    (o_robot_action),
        .o_measure_param   (o_measure_param),
        .o_top_value       (o_top_value),
        .o_stack_depth     (o_stack_depth)
    );

    // Only one word is in flight, so the two sides never overlap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result word waits");

    // A collected result word is not offered again.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid)
        else $error("result word repeated");

    // The data stack never holds more than its depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_stack_depth) <= 32'(DATA_STACK_DEPTH)))
        else $error("data stack depth overrun");

    // Status codes stay within the defined set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_FULL))
        else $error("undefined status code");

endmodule

`default_nettype wire

>>> tb/tb_stack_robot_interpreter_step_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_stack_robot_interpreter_step_unit: self-checking bench of the step unit
// Loads program words and executes steps through the input channel, while a
// cycle-free model of the stack machine predicts every result word. A short
// directed table comes first, then randomised program phases under several
// program lengths, return and data stack fill runs and random stalls.
// ============================================================================
`default_nettype none

module tb_stack_robot_interpreter_step_unit;

    import sri_pkg::*;

    localparam logic FUNC_STEP = ~FUNC_LOAD;
    localparam int   PDEPTH    = 256;
    localparam int   DDEPTH    = 64;
    localparam int   RDEPTH    = 32;

    typedef struct packed {
        logic        func;
        logic [7:0]  addr;
        logic [4:0]  opcode;
        logic [31:0] operand;
        logic [1:0]  outcome;
        logic [31:0] mval;
    } t_word;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] pc;
        logic [2:0]  action;
        logic [31:0] param;
        logic [31:0] top;
        logic [6:0]  depth;
    } t_result;

    typedef enum logic { ROW_CFG, ROW_WORD } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [8:0] length;
        t_word      w;
        bit         typed;
        t_result    want;
    } t_row;

    // Bench signals.
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_func;
    logic [7:0]  i_load_address;
    logic [4:0]  i_load_opcode;
    logic signed [31:0] i_load_operand;
    logic [1:0]  i_move_outcome;
    logic signed [31:0] i_measure_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_status;
    logic signed [31:0] o_program_counter;
    logic [2:0]  o_robot_action;
    logic signed [31:0] o_measure_param;
    logic signed [31:0] o_top_value;
    logic [6:0]  o_stack_depth;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow machine state.
    logic [4:0]  prog_op [PDEPTH];
    logic [31:0] prog_arg [PDEPTH];
    bit          prog_loaded [PDEPTH];
    logic [31:0] dstk [DDEPTH];
    int          dcnt;
    logic [31:0] rstk [RDEPTH];
    int          rcnt;
    logic [31:0] mpc;
    int          plen;

    t_result pending_results[$];
    t_row    directed_rows[$];
    int      errors;
    int      n_words;
    int      n_steps;
    int      n_loads;
    bit [8:0] status_seen;
    bit      calm;
    int      stall_left;

    stack_robot_interpreter_step_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_load_address   (i_load_address),
        .i_load_opcode    (i_load_opcode),
        .i_load_operand   (i_load_operand),
        .i_move_outcome   (i_move_outcome),
        .i_measure_value  (i_measure_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_program_counter(o_program_counter),
        .o_robot_action   (o_robot_action),
        .o_measure_param  (o_measure_param),
        .o_top_value      (o_top_value),
        .o_stack_depth    (o_stack_depth),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #6 i_clk = ~i_clk;

    // Executes one program word on the shadow state and returns its status.
    function automatic logic [3:0] exec_word(input logic [4:0] op, input logic [31:0] arg,
                                             input logic [1:0] outcome,
                                             input logic [31:0] mval,
                                             output logic [2:0] action,
                                             output logic [31:0] param);
        bit          dfull;
        bit          rfull;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        longint      p;
        longint      n;
        longint      sh;
        longint      j;
        logic [31:0] scratch [DDEPTH];
        action = ACT_NONE;
        param  = '0;
        dfull  = dcnt >= DDEPTH;
        rfull  = rcnt >= RDEPTH;
        case (op)
            OP_MOVE: begin
                action = ACT_MOVE;
                if (outcome != 2'd0) return 4'(outcome) + 4'd1;
                mpc++;
            end
            OP_LEFT: begin
                action = ACT_LEFT;
                mpc++;
            end
            OP_RIGHT: begin
                action = ACT_RIGHT;
                mpc++;
            end
            OP_MEASURE: begin
                if (dcnt < 1) return ST_SHORT;
                action = ACT_MEASURE;
                param = dstk[dcnt-1];
                dstk[dcnt-1] = mval;
                mpc++;
            end
            OP_BSTART: begin
                if (dfull) return ST_FULL;
                dstk[dcnt++] = mpc + 32'd1;
                mpc = arg + 32'd1;
            end
            OP_BEND: begin
                if (rcnt == 0) return ST_SHORT;
                mpc = rstk[--rcnt];
            end
            OP_PUSH: begin
                if (dfull) return ST_FULL;
                dstk[dcnt++] = arg;
                mpc++;
            end
            OP_EXEC: begin
                if (dcnt < 1) return ST_SHORT;
                if (rfull) return ST_FULL;
                rstk[rcnt++] = mpc + 32'd1;
                mpc = dstk[--dcnt];
            end
            OP_IFELSE: begin
                if (dcnt < 3) return ST_SHORT;
                if (rfull) return ST_FULL;
                rstk[rcnt++] = mpc + 32'd1;
                mpc = (dstk[dcnt-3] != 0) ? dstk[dcnt-2] : dstk[dcnt-1];
                dcnt -= 3;
            end
            OP_SWAP: begin
                if (dcnt < 2) return ST_SHORT;
                a = dstk[dcnt-1];
                dstk[dcnt-1] = dstk[dcnt-2];
                dstk[dcnt-2] = a;
                mpc++;
            end
            OP_MUL, OP_ADD, OP_DIV, OP_SUB: begin
                if (dcnt < 2) return ST_SHORT;
                a = dstk[dcnt-1];
                b = dstk[dcnt-2];
                dcnt -= 2;
                if (op == OP_MUL) r = b * a;
                else if (op == OP_ADD) r = b + a;
                else if (op == OP_SUB) r = b - a;
                else begin
                    if (a == 0) return ST_DIVZERO;
                    // 64-bit quotient so that the most negative over minus one wraps.
                    p = longint'($signed(b)) / longint'($signed(a));
                    r = p[31:0];
                end
                dstk[dcnt++] = r;
                mpc++;
            end
            OP_ROT: begin
                if (dcnt < 2) return ST_SHORT;
                p = longint'($signed(dstk[dcnt-1]));
                n = longint'($signed(dstk[dcnt-2]));
                dcnt -= 2;
                if (n < 0) n = 0;
                if (n > dcnt) return ST_SHORT;
                if (n > 0) begin
                    sh = p % n;
                    if (sh < 0) sh += n;
                    for (int i = 0; i < n; i++) scratch[i] = dstk[dcnt-1-i];
                    dcnt -= int'(n);
                    for (int i = 1; i <= n; i++) begin
                        j = (n - sh) - i;
                        if (j < 0) j += n;
                        dstk[dcnt++] = scratch[j];
                    end
                end
                mpc++;
            end
            OP_DUP: begin
                if (dcnt < 1) return ST_SHORT;
                if (dfull) return ST_FULL;
                dstk[dcnt] = dstk[dcnt-1];
                dcnt++;
                mpc++;
            end
            OP_LOOP: begin
                if (dcnt < 2) return ST_SHORT;
                n = longint'($signed(dstk[dcnt-1]));
                if (n > 0) begin
                    if (rfull) return ST_FULL;
                    dstk[dcnt-1] = dstk[dcnt-1] - 32'd1;
                    rstk[rcnt++] = mpc;
                    mpc = dstk[dcnt-2];
                end else begin
                    dcnt -= 2;
                    mpc++;
                end
            end
            OP_DROP: begin
                if (dcnt < 1) return ST_SHORT;
                dcnt--;
                mpc++;
            end
            default: mpc++;
        endcase
        return ST_OK;
    endfunction

    // Applies one input word to the shadow state and forms its result word.
    function automatic t_result predict_result(input t_word w);
        t_result r;
        longint  spc;
        r = '0;
        r.status = ST_OK;
        if (w.func == FUNC_LOAD) begin
            prog_op[w.addr]     = w.opcode;
            prog_arg[w.addr]    = w.operand;
            prog_loaded[w.addr] = 1'b1;
        end else begin
            spc = longint'($signed(mpc));
            if (spc == plen) r.status = ST_STOPPED;
            else if (spc < 0 || spc > plen || spc >= PDEPTH) r.status = ST_BADADDR;
            else begin
                r.status = exec_word(prog_op[spc], prog_arg[spc], w.outcome, w.mval,
                                     r.action, r.param);
                if (r.status == ST_OK && longint'($signed(mpc)) == plen)
                    r.status = ST_STOPPED;
            end
        end
        r.pc    = mpc;
        r.top   = (dcnt > 0) ? dstk[dcnt-1] : 32'd0;
        r.depth = 7'(dcnt);
        return r;
    endfunction

    function automatic t_word mk_load(input logic [7:0] addr, input logic [4:0] op,
                                      input logic [31:0] arg);
        t_word w;
        w.func    = FUNC_LOAD;
        w.addr    = addr;
        w.opcode  = op;
        w.operand = arg;
        w.outcome = 2'($urandom);
        w.mval    = $urandom;
        return w;
    endfunction

    function automatic t_word mk_step(input logic [1:0] outcome, input logic [31:0] mval);
        t_word w;
        w.func    = FUNC_STEP;
        w.addr    = 8'($urandom);
        w.opcode  = 5'($urandom_range(0, 18));
        w.operand = $urandom;
        w.outcome = outcome;
        w.mval    = mval;
        return w;
    endfunction

    function automatic t_result mk_result(input logic [3:0] st, input logic [31:0] pc,
                                          input logic [2:0] act, input logic [31:0] param,
                                          input logic [31:0] top, input logic [6:0] depth);
        t_result r;
        r.status = st;
        r.pc     = pc;
        r.action = act;
        r.param  = param;
        r.top    = top;
        r.depth  = depth;
        return r;
    endfunction

    function automatic void add_cfg(input logic [8:0] length);
        t_row row;
        row.kind   = ROW_CFG;
        row.length = length;
        row.w      = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_word(input t_word w, input bit typed, input t_result want);
        t_row row;
        row.kind   = ROW_WORD;
        row.length = '0;
        row.w      = w;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // A jump that leaves 0..256 could never be recovered from, so most are avoided.
    function automatic bit jump_sane();
        logic [31:0] dest;
        longint      spc;
        spc = longint'($signed(mpc));
        if (spc < 0 || spc >= plen || spc >= PDEPTH) return 1'b1;
        dest = mpc;
        case (prog_op[spc])
            OP_BSTART: dest = prog_arg[spc] + 32'd1;
            OP_EXEC:   if (dcnt >= 1) dest = dstk[dcnt-1];
            OP_IFELSE: if (dcnt >= 3) dest = (dstk[dcnt-3] != 0) ? dstk[dcnt-2] : dstk[dcnt-1];
            OP_LOOP:   if (dcnt >= 2 && $signed(dstk[dcnt-1]) > 0) dest = dstk[dcnt-2];
            default:   dest = mpc;
        endcase
        return $signed(dest) >= 0 && $signed(dest) <= PDEPTH;
    endfunction

    // A program word with mostly small operands so that jumps stay in the program.
    function automatic t_word random_program_word(input logic [7:0] addr);
        logic [4:0]  op;
        logic [31:0] arg;
        int          roll;
        int          span;
        span = (plen > 0) ? plen - 1 : 0;
        op   = ($urandom_range(0, 99) < 30) ? OP_PUSH : 5'($urandom_range(0, 18));
        roll = $urandom_range(0, 99);
        if (op == OP_BSTART) arg = 32'($urandom_range(0, span)) - 32'd1;
        else if (roll < 60) arg = 32'($urandom_range(0, span));
        else if (roll < 85) arg = 32'($urandom_range(0, 5)) - 32'd1;
        else arg = $urandom;
        return mk_load(addr, op, arg);
    endfunction

    // Presents one input word and records what it must produce.
    task automatic send_word(input t_word w, input bit typed, input t_result want);
        t_result r;
        int      k;
        if (!calm && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (k) @(posedge i_clk);
        end
        i_func          <= w.func;
        i_load_address  <= w.addr;
        i_load_opcode   <= w.opcode;
        i_load_operand  <= w.operand;
        i_move_outcome  <= w.outcome;
        i_measure_value <= w.mval;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_result(w);
        if (typed) r = want;
        pending_results.push_back(r);
        n_words++;
        if (w.func == FUNC_LOAD) n_loads++;
        else n_steps++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Writes program_length through the configuration port, with the block idle.
    task automatic write_length(input logic [8:0] length);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * REG_PROGRAM_LENGTH);
        pwdata  <= 32'(length);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        plen = int'(length);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // One execution step, preceded by a load where the word at pc needs one, and now and then by a random load.
    task automatic step_once();
        longint spc;
        spc = longint'($signed(mpc));
        if ($urandom_range(0, 11) == 0)
            send_word(mk_load(8'($urandom), 5'($urandom_range(0, 18)), $urandom), 0, '0);
        if (spc >= 0 && spc < plen && spc < PDEPTH && !prog_loaded[spc])
            send_word(random_program_word(8'(spc)), 0, '0);
        else if (!jump_sane() && $urandom_range(0, 7) != 0)
            send_word(mk_load(8'(spc), OP_PUSH, 32'($urandom_range(0, 9))), 0, '0);
        send_word(mk_step(($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd0, $urandom),
                  0, '0);
    endtask

    task automatic random_phase(input int steps);
        longint spc;
        int     roll;
        int     length;
        spc  = longint'($signed(mpc));
        roll = $urandom_range(0, 19);
        if (roll == 0) length = 0;
        else if (roll == 1) length = PDEPTH;
        else if (roll == 2 && spc >= 0 && spc <= PDEPTH) length = int'(spc);
        else if (spc >= 0 && spc < PDEPTH) length = int'(spc) + $urandom_range(1, 16);
        else length = $urandom_range(1, 20);
        if (length > PDEPTH) length = PDEPTH;
        write_length(9'(length));
        repeat (steps) step_once();
    endtask

    // Two-word program at pc that loops forever while pushing onto one stack.
    task automatic fill_phase(input bit data_side, input int steps);
        int base;
        base = int'($signed(mpc));
        if (base < 0 || base > PDEPTH - 2) return;
        write_length(9'(base + 2));
        send_word(mk_load(8'(base), OP_PUSH, data_side ? $urandom : 32'(base)), 0, '0);
        send_word(mk_load(8'(base + 1), data_side ? OP_BSTART : OP_EXEC,
                          32'(base - 1)), 0, '0);
        repeat (steps) send_word(mk_step(2'($urandom), $urandom), 0, '0);
    endtask

    // Result words are compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected (status %0d pc %0d)",
                         $time, o_status, o_program_counter);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.status <= ST_FULL) status_seen[want.status] = 1'b1;
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_program_counter !== want.pc) begin
                    $display("%0t: pc expected %0d actual %0d",
                             $time, $signed(want.pc), o_program_counter);
                    errors++;
                end
                if (o_robot_action !== want.action) begin
                    $display("%0t: action expected %0d actual %0d",
                             $time, want.action, o_robot_action);
                    errors++;
                end
                if (o_measure_param !== want.param) begin
                    $display("%0t: measure param expected %h actual %h",
                             $time, want.param, o_measure_param);
                    errors++;
                end
                if (o_top_value !== want.top) begin
                    $display("%0t: top expected %h actual %h", $time, want.top, o_top_value);
                    errors++;
                end
                if (o_stack_depth !== want.depth) begin
                    $display("%0t: depth expected %0d actual %0d",
                             $time, want.depth, o_stack_depth);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls in short random bursts.
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #20ms;
        $display("Timeout with %0d result words outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row row;
        int   guard;
        errors = 0;
        n_words = 0;
        n_steps = 0;
        n_loads = 0;
        status_seen = '0;
        calm = 1'b0;
        stall_left = 0;
        dcnt = 0;
        rcnt = 0;
        mpc  = '0;
        plen = 0;
        foreach (prog_loaded[i]) prog_loaded[i] = 1'b0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_out_ready     <= 1'b0;
        i_func          <= FUNC_LOAD;
        i_load_address  <= '0;
        i_load_opcode   <= OP_MOVE;
        i_load_operand  <= '0;
        i_move_outcome  <= '0;
        i_measure_value <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: arithmetic at the extremes, measure, a crash, divide by
        // zero, a short stack, stopping at the end and the top load address.
        add_cfg(9'd0);
        add_word(mk_step(2'd0, 32'd0), 1, mk_result(ST_STOPPED, 0, ACT_NONE, 0, 0, 0));
        add_word(mk_load(8'd0, OP_PUSH, 32'h7FFF_FFFF), 1,
                 mk_result(ST_OK, 0, ACT_NONE, 0, 0, 0));
        add_word(mk_load(8'd1, OP_PUSH, 32'h8000_0000), 0, '0);
        add_word(mk_load(8'd2, OP_ADD, 32'hFFFF_FFFF), 0, '0);
        add_word(mk_load(8'd3, OP_MEASURE, 32'd0), 0, '0);
        add_word(mk_load(8'd4, OP_MOVE, 32'd0), 0, '0);
        add_word(mk_load(8'd5, OP_DUP, 32'd0), 0, '0);
        add_word(mk_load(8'd6, OP_PUSH, 32'd0), 0, '0);
        add_word(mk_load(8'd7, OP_DIV, 32'd0), 0, '0);
        add_word(mk_load(8'd255, OP_DROP, 32'hFFFF_FFFF), 1,
                 mk_result(ST_OK, 0, ACT_NONE, 0, 0, 0));
        add_cfg(9'd8);
        add_word(mk_step(2'd0, 32'd0), 1,
                 mk_result(ST_OK, 1, ACT_NONE, 0, 32'h7FFF_FFFF, 1));
        add_word(mk_step(2'd0, 32'd0), 1,
                 mk_result(ST_OK, 2, ACT_NONE, 0, 32'h8000_0000, 2));
        add_word(mk_step(2'd0, 32'd0), 1,
                 mk_result(ST_OK, 3, ACT_NONE, 0, 32'hFFFF_FFFF, 1));
        add_word(mk_step(2'd0, 32'h8000_0000), 1,
                 mk_result(ST_OK, 4, ACT_MEASURE, 32'hFFFF_FFFF, 32'h8000_0000, 1));
        add_word(mk_step(2'd2, 32'd0), 1,
                 mk_result(ST_CRASH, 4, ACT_MOVE, 0, 32'h8000_0000, 1));
        add_word(mk_step(2'd3, 32'd0), 1,
                 mk_result(ST_OFFMAP, 4, ACT_MOVE, 0, 32'h8000_0000, 1));
        add_word(mk_step(2'd0, 32'hFFFF_FFFF), 0, '0);
        add_word(mk_step(2'd0, 32'd0), 0, '0);
        add_word(mk_step(2'd0, 32'd0), 0, '0);
        add_word(mk_step(2'd0, 32'd0), 1,
                 mk_result(ST_DIVZERO, 7, ACT_NONE, 0, 32'h8000_0000, 1));
        add_word(mk_step(2'd0, 32'd0), 1,
                 mk_result(ST_SHORT, 7, ACT_NONE, 0, 32'h8000_0000, 1));
        add_word(mk_load(8'd7, OP_DROP, 32'd0), 0, '0);
        add_word(mk_step(2'd0, 32'd0), 1, mk_result(ST_STOPPED, 8, ACT_NONE, 0, 0, 0));
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) write_length(row.length);
            else send_word(row.w, row.typed, row.want);
        end

        // Random program phases, with the return stack driven to full early on.
        random_phase(20);
        fill_phase(1'b0, 70);
        while (n_words < 160) random_phase($urandom_range(8, 30));
        wait_idle();
        random_phase(10);
        random_phase(12);
        fill_phase(1'b1, 140);
        random_phase(20);
        calm = 1'b1;
        random_phase(30);

        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        $display("Covered %0d words: %0d steps and %0d loads over several program lengths.",
                 n_words, n_steps, n_loads);
        $display("Status codes reached (bit per code): %b", status_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
